@@ src/fdg_pkg.sv @@
// types and constants shared by the forward-difference gradient block
// no dependencies; every other file refers to it by scoped names
package fdg_pkg;

    localparam int MAX_X       = 256;
    localparam int MAX_Y       = 256;
    localparam int MAX_Z       = 256;
    localparam int SAMPLE_BITS = 16;
    localparam int DIFF_BITS   = SAMPLE_BITS + 1;

    localparam int XW = $clog2(MAX_X);
    localparam int YW = $clog2(MAX_Y);
    localparam int ZW = $clog2(MAX_Z);

    localparam int SIZE_W     = 9;
    localparam int CFG_DATA_W = 9;
    localparam int CFG_IDX_W  = 3;

    localparam int RING_DEPTH  = MAX_X * MAX_Y + MAX_X;
    localparam int RW          = $clog2(RING_DEPTH);
    localparam int PLANE_DEPTH = MAX_X * MAX_Y;
    localparam int PW          = $clog2(PLANE_DEPTH);
    localparam int ROW_DEPTH   = 2 * MAX_X;

    localparam int FIFO_DEPTH = 4;
    localparam int FAW        = $clog2(FIFO_DEPTH);
    localparam int FCW        = $clog2(FIFO_DEPTH + 1);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AXES     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUNDARY = 3'd4;

    // boundary rules
    localparam logic [1:0] MODE_NONE     = 2'd0;
    localparam logic [1:0] MODE_NEUMANN  = 2'd1;
    localparam logic [1:0] MODE_PERIODIC = 2'd2;
    localparam logic [1:0] MODE_SPARE    = 2'd3;

    // axis counts
    localparam logic [1:0] AXES_ZERO = 2'd0;
    localparam logic [1:0] AXES_X    = 2'd1;
    localparam logic [1:0] AXES_XY   = 2'd2;
    localparam logic [1:0] AXES_XYZ  = 2'd3;

    // request kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_DRAIN  = 1'b1;

    // effective configuration
    typedef struct packed {
        logic [SIZE_W-1:0] nx;
        logic [XW-1:0]     x_last;
        logic [YW-1:0]     y_last;
        logic [ZW-1:0]     z_last;
        logic [1:0]        axes;
        logic [1:0]        mode;
        logic              x_use_in;
        logic              y_use_in;
    } cfg_t;

    // one voxel handed from front to back
    typedef struct packed {
        logic                   valid;
        logic                   x_first;
        logic                   x_last;
        logic                   y_last;
        logic                   z_last;
        logic                   vox_last;
        logic [SAMPLE_BITS-1:0] s;
        logic [SAMPLE_BITS-1:0] c;
        logic [SAMPLE_BITS-1:0] nbx;
        logic [SAMPLE_BITS-1:0] nby;
        logic [SAMPLE_BITS-1:0] frow;
        logic [SAMPLE_BITS-1:0] fplane;
    } job_t;

    // queue status seen by the front
    typedef struct packed {
        logic [FCW-1:0] count;
    } credit_t;

    typedef struct packed {
        logic [DIFF_BITS-1:0] diff_x;
        logic [DIFF_BITS-1:0] diff_y;
        logic [DIFF_BITS-1:0] diff_z;
        logic                 edge_x;
        logic                 edge_y;
        logic                 edge_z;
        logic                 last;
    } result_t;

endpackage

@@ src/fdg_if.sv @@
// request channels of the gradient block: voxel stream in, gradient out
// depends on fdg_pkg
interface fdg_voxel_if;
    logic                                    valid;
    logic                                    ready;
    logic                                    kind;
    logic signed [fdg_pkg::SAMPLE_BITS-1:0]  sample;

    modport source (output valid, kind, sample, input ready);
    modport sink (input valid, kind, sample, output ready);
endinterface

interface fdg_grad_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [fdg_pkg::DIFF_BITS-1:0]  diff_x;
    logic signed [fdg_pkg::DIFF_BITS-1:0]  diff_y;
    logic signed [fdg_pkg::DIFF_BITS-1:0]  diff_z;
    logic                                  edge_x;
    logic                                  edge_y;
    logic                                  edge_z;
    logic                                  last;

    modport source (output valid, diff_x, diff_y, diff_z, edge_x, edge_y, edge_z, last,
                    input ready);
    modport sink (input valid, diff_x, diff_y, diff_z, edge_x, edge_y, edge_z, last,
                  output ready);
endinterface

@@ src/fdg_front.sv @@
// front end: accepts requests, tracks positions, holds the sample stores
// depends on fdg_pkg and fdg_if
module fdg_front (
    input  logic               clk,
    input  logic               rst_n,
    fdg_voxel_if.sink          voxel,
    input  fdg_pkg::cfg_t      cfg,
    input  logic               restart,
    input  fdg_pkg::credit_t   credit,
    output fdg_pkg::job_t      job
);

    localparam int SB = fdg_pkg::SAMPLE_BITS;
    localparam int RW = fdg_pkg::RW;

    // positions
    logic [fdg_pkg::XW-1:0] xq_reg, xp_reg;
    logic [fdg_pkg::YW-1:0] yq_reg, yp_reg;
    logic [fdg_pkg::ZW-1:0] zq_reg, zp_reg;
    logic [fdg_pkg::PW-1:0] qpi_reg, ppi_reg;
    logic [RW-1:0]          wq_reg, rc_reg;
    logic                   q_done_reg;
    logic                   job_valid_reg;

    // job payload
    logic          x_first_reg, x_last_reg, y_last_reg, z_last_reg, vox_last_reg;
    logic [SB-1:0] s_reg, c_reg, nbx_reg, nby_reg, frow_reg, fplane_reg;

    // stores
    logic [SB-1:0] ring_c   [fdg_pkg::RING_DEPTH];
    logic [SB-1:0] ring_x   [fdg_pkg::RING_DEPTH];
    logic [SB-1:0] ring_y   [fdg_pkg::RING_DEPTH];
    logic [SB-1:0] plane0   [fdg_pkg::PLANE_DEPTH];
    logic [SB-1:0] row0     [fdg_pkg::ROW_DEPTH];

    logic          accept, is_sample, q_start, emit, p_all_last, restart_all;
    logic          xq_l, yq_l, zq_l, xp_l, yp_l, zp_l;
    logic [RW:0]   rx_sum, ry_sum;
    logic [RW-1:0] rx, ry, wq_inc, rc_inc;
    logic [fdg_pkg::FCW:0] busy;

    // credit check against the result queue
    assign busy        = {1'b0, credit.count} + {{fdg_pkg::FCW{1'b0}}, job_valid_reg};
    assign voxel.ready = busy < (fdg_pkg::FCW + 1)'(fdg_pkg::FIFO_DEPTH);
    assign accept      = voxel.valid && voxel.ready;

    // classify the request
    always_comb
    begin
        case (cfg.axes)
            fdg_pkg::AXES_XY:  q_start = (yq_reg == '0) && (zq_reg == '0);
            fdg_pkg::AXES_XYZ: q_start = (zq_reg == '0);
            default:           q_start = (xq_reg == '0) && (yq_reg == '0) && (zq_reg == '0);
        endcase
    end

    assign xq_l = (xq_reg == cfg.x_last);
    assign yq_l = (yq_reg == cfg.y_last);
    assign zq_l = (zq_reg == cfg.z_last);
    assign xp_l = (xp_reg == cfg.x_last);
    assign yp_l = (yp_reg == cfg.y_last);
    assign zp_l = (zp_reg == cfg.z_last);
    assign p_all_last = xp_l && yp_l && zp_l;

    assign is_sample   = accept && (voxel.kind == fdg_pkg::KIND_SAMPLE) && !q_done_reg;
    assign emit        = accept && (q_done_reg ||
                         ((voxel.kind == fdg_pkg::KIND_SAMPLE) && !q_start));
    assign restart_all = restart || (emit && p_all_last);

    // ring addresses of the neighbours, wrapped
    assign rx_sum = {1'b0, rc_reg} + (RW + 1)'(1);
    assign ry_sum = {1'b0, rc_reg} + (RW + 1)'(cfg.nx);
    assign rx = (rx_sum >= (RW + 1)'(fdg_pkg::RING_DEPTH)) ?
                RW'(rx_sum - (RW + 1)'(fdg_pkg::RING_DEPTH)) : RW'(rx_sum);
    assign ry = (ry_sum >= (RW + 1)'(fdg_pkg::RING_DEPTH)) ?
                RW'(ry_sum - (RW + 1)'(fdg_pkg::RING_DEPTH)) : RW'(ry_sum);
    assign wq_inc = (wq_reg == RW'(fdg_pkg::RING_DEPTH - 1)) ? '0 : wq_reg + RW'(1);
    assign rc_inc = (rc_reg == RW'(fdg_pkg::RING_DEPTH - 1)) ? '0 : rc_reg + RW'(1);

    // position counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xq_reg <= '0; yq_reg <= '0; zq_reg <= '0; qpi_reg <= '0; wq_reg <= '0;
            xp_reg <= '0; yp_reg <= '0; zp_reg <= '0; ppi_reg <= '0; rc_reg <= '0;
            q_done_reg    <= 1'b0;
            job_valid_reg <= 1'b0;
        end
        else
        begin
            job_valid_reg <= emit;
            if (restart_all)
            begin
                xq_reg <= '0; yq_reg <= '0; zq_reg <= '0; qpi_reg <= '0; wq_reg <= '0;
                xp_reg <= '0; yp_reg <= '0; zp_reg <= '0; ppi_reg <= '0; rc_reg <= '0;
                q_done_reg <= 1'b0;
            end
            else
            begin
                if (is_sample)
                begin
                    wq_reg  <= wq_inc;
                    qpi_reg <= (xq_l && yq_l) ? '0 : qpi_reg + fdg_pkg::PW'(1);
                    xq_reg  <= xq_l ? '0 : xq_reg + fdg_pkg::XW'(1);
                    if (xq_l)
                    begin
                        yq_reg <= yq_l ? '0 : yq_reg + fdg_pkg::YW'(1);
                        if (yq_l)
                        begin
                            zq_reg <= zq_l ? '0 : zq_reg + fdg_pkg::ZW'(1);
                        end
                    end
                    if (xq_l && yq_l && zq_l)
                    begin
                        q_done_reg <= 1'b1;
                    end
                end
                if (emit)
                begin
                    rc_reg  <= rc_inc;
                    ppi_reg <= (xp_l && yp_l) ? '0 : ppi_reg + fdg_pkg::PW'(1);
                    xp_reg  <= xp_l ? '0 : xp_reg + fdg_pkg::XW'(1);
                    if (xp_l)
                    begin
                        yp_reg <= yp_l ? '0 : yp_reg + fdg_pkg::YW'(1);
                        if (yp_l)
                        begin
                            zp_reg <= zp_l ? '0 : zp_reg + fdg_pkg::ZW'(1);
                        end
                    end
                end
            end
        end
    end

    // job flags
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            x_first_reg  <= (xp_reg == '0);
            x_last_reg   <= xp_l;
            y_last_reg   <= yp_l;
            z_last_reg   <= zp_l;
            vox_last_reg <= p_all_last;
            s_reg        <= voxel.sample;
        end
    end

    // sample stores: write on a new sample
    always_ff @(posedge clk)
    begin
        if (is_sample)
        begin
            ring_c[wq_reg] <= voxel.sample;
            ring_x[wq_reg] <= voxel.sample;
            ring_y[wq_reg] <= voxel.sample;
            if (zq_reg == '0)
            begin
                plane0[qpi_reg] <= voxel.sample;
            end
            if (yq_reg == '0)
            begin
                row0[{zq_reg[0], xq_reg}] <= voxel.sample;
            end
        end
    end

    // sample stores: registered reads for the voxel going out
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            c_reg      <= ring_c[rc_reg];
            nbx_reg    <= ring_x[rx];
            nby_reg    <= ring_y[ry];
            fplane_reg <= plane0[ppi_reg];
            frow_reg   <= row0[{zp_reg[0], xp_reg}];
        end
    end

    assign job.valid    = job_valid_reg;
    assign job.x_first  = x_first_reg;
    assign job.x_last   = x_last_reg;
    assign job.y_last   = y_last_reg;
    assign job.z_last   = z_last_reg;
    assign job.vox_last = vox_last_reg;
    assign job.s        = s_reg;
    assign job.c        = c_reg;
    assign job.nbx      = nbx_reg;
    assign job.nby      = nby_reg;
    assign job.frow     = frow_reg;
    assign job.fplane   = fplane_reg;

    // a job only follows an accepted request
    a_job_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid_reg |-> $past(voxel.valid && voxel.ready))
        else $error("job without accepted request");

    // restart clears the input position
    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        restart |=> (!q_done_reg && xq_reg == '0 && zq_reg == '0))
        else $error("restart left input position set");

endmodule

@@ src/fdg_back.sv @@
// back end: forms the differences and queues results for the receiver
// depends on fdg_pkg and fdg_if
module fdg_back (
    input  logic               clk,
    input  logic               rst_n,
    input  fdg_pkg::job_t      job,
    input  fdg_pkg::cfg_t      cfg,
    output fdg_pkg::credit_t   credit,
    fdg_grad_if.source         grad
);

    localparam int SB = fdg_pkg::SAMPLE_BITS;
    localparam int DB = fdg_pkg::DIFF_BITS;

    logic [SB-1:0]          fir_reg;
    fdg_pkg::result_t       fifo_reg [fdg_pkg::FIFO_DEPTH];
    logic [fdg_pkg::FAW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [fdg_pkg::FCW-1:0] count_reg;

    fdg_pkg::result_t res;
    logic [SB-1:0]    fir_eff, xn, yn;
    logic             periodic, flagged, push, pop;

    function automatic logic [DB-1:0] sub_ext(input logic [SB-1:0] a, input logic [SB-1:0] b);
        sub_ext = {a[SB-1], a} - {b[SB-1], b};
    endfunction

    assign fir_eff  = job.x_first ? job.c : fir_reg;
    assign xn       = cfg.x_use_in ? job.s : job.nbx;
    assign yn       = cfg.y_use_in ? job.s : job.nby;
    assign periodic = (cfg.mode == fdg_pkg::MODE_PERIODIC);
    assign flagged  = (cfg.mode == fdg_pkg::MODE_NONE);

    // differences and boundary flags
    always_comb
    begin
        res = '0;
        if (!job.x_last)
            res.diff_x = sub_ext(xn, job.c);
        else if (periodic)
            res.diff_x = sub_ext(fir_eff, job.c);
        else
            res.edge_x = flagged;
        if (cfg.axes != fdg_pkg::AXES_X)
        begin
            if (!job.y_last)
                res.diff_y = sub_ext(yn, job.c);
            else if (periodic)
                res.diff_y = sub_ext(job.frow, job.c);
            else
                res.edge_y = flagged;
        end
        if (cfg.axes == fdg_pkg::AXES_XYZ)
        begin
            if (!job.z_last)
                res.diff_z = sub_ext(job.s, job.c);
            else if (periodic)
                res.diff_z = sub_ext(job.fplane, job.c);
            else
                res.edge_z = flagged;
        end
        res.last = job.vox_last;
    end

    // first sample of the current row
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fir_reg <= '0;
        else if (job.valid && job.x_first)
            fir_reg <= job.c;
    end

    // result queue
    assign push = job.valid;
    assign pop  = grad.valid && grad.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + fdg_pkg::FAW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + fdg_pkg::FAW'(1);
            count_reg <= count_reg + fdg_pkg::FCW'(push) - fdg_pkg::FCW'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wr_ptr_reg] <= res;
    end

    assign credit.count = count_reg;
    assign grad.valid   = (count_reg != '0);
    assign grad.diff_x  = fifo_reg[rd_ptr_reg].diff_x;
    assign grad.diff_y  = fifo_reg[rd_ptr_reg].diff_y;
    assign grad.diff_z  = fifo_reg[rd_ptr_reg].diff_z;
    assign grad.edge_x  = fifo_reg[rd_ptr_reg].edge_x;
    assign grad.edge_y  = fifo_reg[rd_ptr_reg].edge_y;
    assign grad.edge_z  = fifo_reg[rd_ptr_reg].edge_z;
    assign grad.last    = fifo_reg[rd_ptr_reg].last;

    // queue never overfills
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |-> (count_reg < fdg_pkg::FCW'(fdg_pkg::FIFO_DEPTH)))
        else $error("result queue overflow");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= fdg_pkg::FCW'(fdg_pkg::FIFO_DEPTH))
        else $error("result queue count out of range");

endmodule

@@ src/forward_difference_gradient.sv @@
// Streaming forward-difference gradient over a raster-order volume.
// voxel: sink channel of requests; kind 0 carries a sample, kind 1 is a
//   drain tick that flushes one pending result once the volume is in.
// grad: source channel of results, one per voxel, with diff_x/y/z,
//   edge flags and last on the final voxel of the volume.
// cfg_we/cfg_index/cfg_data: register writes, taken at any edge with
//   cfg_we high; a write to a listed register restarts the stream.
// Throughput: one request per cycle while voxel.ready is high. An accepted
//   request goes into the job register, and its result is then written
//   into the output queue, which raises grad.valid;
//   results lag the inputs by the stride of the highest axis in use
//   (1, size_x or size_x*size_y voxels).
// The rate is set by the sample stores, each taking one write and one
//   registered read per cycle.
// When grad is stalled, results collect in a four-entry queue; voxel.ready
//   drops once queued plus in-flight results fill it.
// Reset: sizes 256, three axes, Neumann boundary, stream at position zero.
//   Stores are not cleared; each read whose value is used hits a written entry.
// depends on fdg_pkg, fdg_if, fdg_front and fdg_back
module forward_difference_gradient (
    input  logic                              clk,
    input  logic                              rst_n,
    fdg_voxel_if.sink                         voxel,
    fdg_grad_if.source                        grad,
    input  logic                              cfg_we,
    input  logic [fdg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fdg_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int SW = fdg_pkg::SIZE_W;

    logic [SW-1:0] size_x_reg, size_y_reg, size_z_reg;
    logic [1:0]    axes_reg, mode_reg;
    logic [SW-1:0] nx, ny, nz;
    logic          restart;

    fdg_pkg::cfg_t    cfg;
    fdg_pkg::job_t    job;
    fdg_pkg::credit_t credit;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg <= SW'(256);
            size_y_reg <= SW'(256);
            size_z_reg <= SW'(256);
            axes_reg   <= fdg_pkg::AXES_XYZ;
            mode_reg   <= fdg_pkg::MODE_NEUMANN;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fdg_pkg::CFG_SIZE_X:   size_x_reg <= cfg_data;
                fdg_pkg::CFG_SIZE_Y:   size_y_reg <= cfg_data;
                fdg_pkg::CFG_SIZE_Z:   size_z_reg <= cfg_data;
                fdg_pkg::CFG_AXES:     axes_reg   <= cfg_data[1:0];
                fdg_pkg::CFG_BOUNDARY: mode_reg   <= cfg_data[1:0];
                default:               ;
            endcase
        end
    end

    assign restart = cfg_we && (cfg_index <= fdg_pkg::CFG_BOUNDARY);

    // effective sizes and modes
    always_comb
    begin
        nx = (size_x_reg == '0) ? SW'(1) :
             (size_x_reg > SW'(fdg_pkg::MAX_X)) ? SW'(fdg_pkg::MAX_X) : size_x_reg;
        ny = (size_y_reg == '0) ? SW'(1) :
             (size_y_reg > SW'(fdg_pkg::MAX_Y)) ? SW'(fdg_pkg::MAX_Y) : size_y_reg;
        nz = (size_z_reg == '0) ? SW'(1) :
             (size_z_reg > SW'(fdg_pkg::MAX_Z)) ? SW'(fdg_pkg::MAX_Z) : size_z_reg;
        cfg.nx     = nx;
        cfg.x_last = fdg_pkg::XW'(nx - SW'(1));
        cfg.y_last = fdg_pkg::YW'(ny - SW'(1));
        cfg.z_last = fdg_pkg::ZW'(nz - SW'(1));
        cfg.axes   = (axes_reg == fdg_pkg::AXES_ZERO) ? fdg_pkg::AXES_X : axes_reg;
        cfg.mode   = (mode_reg == fdg_pkg::MODE_SPARE) ? fdg_pkg::MODE_NONE : mode_reg;
        // a neighbour at the stride is the sample arriving now
        cfg.x_use_in = (cfg.axes == fdg_pkg::AXES_X) ||
                       ((cfg.axes == fdg_pkg::AXES_XY) && (nx == SW'(1))) ||
                       ((cfg.axes == fdg_pkg::AXES_XYZ) && (nx == SW'(1)) && (ny == SW'(1)));
        cfg.y_use_in = (cfg.axes == fdg_pkg::AXES_XY) ||
                       ((cfg.axes == fdg_pkg::AXES_XYZ) && (ny == SW'(1)));
    end

    fdg_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .voxel   (voxel),
        .cfg     (cfg),
        .restart (restart),
        .credit  (credit),
        .job     (job)
    );

    fdg_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .job    (job),
        .cfg    (cfg),
        .credit (credit),
        .grad   (grad)
    );

endmodule
